// ===== rtl/core/tqpm_pkg.sv =====
// ----------------------------------------------------------------------------
// Two-queue priority merge: shared package
// Types, codes and sizes used by the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package tqpm_pkg;

    localparam int QUEUE_DEPTH = 256;
    localparam int ID_W        = 16;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        ACT_PUSH_ONE = 3'd0,
        ACT_PUSH_TWO = 3'd1,
        ACT_ROUND    = 3'd2,
        ACT_POP_ONE  = 3'd3,
        ACT_POP_TWO  = 3'd4
    } act_t;

    typedef enum logic [1:0] {
        ST_GRANT = 2'd0,
        ST_DRAIN = 2'd1,
        ST_DROP  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        SEL_ZERO,
        SEL_HEAD_ONE,
        SEL_HEAD_TWO
    } id_sel_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_SECOND
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load_item;
        logic    push_one;
        logic    push_two;
        logic    pop_one;
        logic    pop_two;
        logic    emit;
        id_sel_t id_sel;
        logic    from_line;
        status_t status;
        logic    last;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        act_t action;
        logic empty_one;
        logic empty_two;
        logic full_one;
        logic full_two;
        logic head_lt;
        logic head_eq;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== rtl/core/two_queue_priority_merge_top.sv =====
// ----------------------------------------------------------------------------
// Two-queue priority merge: top level
// Keeps two FIFO lines of ids, merges their heads in dispense rounds and
// drains leftovers on request.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  tdata              tuser                    tlast
//   s_       in         person_id [15:0]   action [2:0]             -
//   m_       out        out_id [15:0]      from_line, status [2:1]  last_of_item
//
// An item passes through the transfer step, in which both line heads are
// read from their stores, and an evaluation step that compares the heads
// and writes any result into the output register. A round with equal heads
// takes an extra step for the second grant, since there is a single result
// register. A full output register stalls evaluation until the downstream
// side takes its transfer. Reset clears the pointers and fill counts at
// once; the line stores are not cleared and need no sweep.
// ----------------------------------------------------------------------------
module two_queue_priority_merge_top
    import tqpm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] person_id
    input  logic [2:0]  s_tuser,   // [2:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] out_id
    output logic [2:0]  m_tuser,   // [0] from_line, [2:1] status
    output logic        m_tlast    // last_of_item
);

    dp_cmd_t  cmd;
    dp_stat_t stat;
    status_t  out_status;
    logic     out_line;

    // The controller owns sequencing; besides the input valid it only sees the datapath's status flags.
    tqpm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds both line stores, pointers and the output register.
    tqpm_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_action  (act_t'(s_tuser)),
        .in_id      (s_tdata[ID_W-1:0]),
        .cmd        (cmd),
        .stat       (stat),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_id     (m_tdata),
        .out_line   (out_line),
        .out_status (out_status),
        .out_last   (m_tlast)
    );

    assign m_tuser = {out_status, out_line};

`ifndef NO_ASSERTIONS
    // An accepted item keeps the input closed for at least its evaluation cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted during evaluation");

    // Error results carry a zero id.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[2:1] == ST_DROP || m_tuser[2:1] == ST_EMPTY))
        |-> (m_tdata == '0))
        else $error("error result with nonzero id");

    // Only the first grant of an equal-heads round is not the last result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tuser[0] == 1'b0 && m_tuser[2:1] == ST_GRANT))
        else $error("unexpected non-final result");

    // The datapath never pushes and pops the same line in one cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.push_one && cmd.pop_one) && !(cmd.push_two && cmd.pop_two))
        else $error("push and pop on one line together");
`endif

endmodule

// ===== rtl/core/tqpm_dp.sv =====
// ----------------------------------------------------------------------------
// Two-queue priority merge: datapath
// Two line stores with head/tail/fill pointers, head read registers, the
// held input item and the result output register.
// ----------------------------------------------------------------------------
module tqpm_dp
    import tqpm_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  act_t            in_action,
    input  logic [ID_W-1:0] in_id,
    input  dp_cmd_t         cmd,
    output dp_stat_t        stat,
    input  logic            out_ready,
    output logic            out_valid,
    output logic [ID_W-1:0] out_id,
    output logic            out_line,
    output status_t         out_status,
    output logic            out_last
);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    logic [ID_W-1:0] line_one_mem [QUEUE_DEPTH];
    logic [ID_W-1:0] line_two_mem [QUEUE_DEPTH];

    logic [PTR_W-1:0]  head_one_reg, head_one_next, tail_one_reg, tail_one_next;
    logic [PTR_W-1:0]  head_two_reg, head_two_next, tail_two_reg, tail_two_next;
    logic [FILL_W-1:0] fill_one_reg, fill_one_next, fill_two_reg, fill_two_next;
    logic [ID_W-1:0]   rd_one_reg, rd_two_reg;
    act_t              action_reg;
    logic [ID_W-1:0]   id_reg;
    logic              out_valid_reg, out_valid_next;
    logic [ID_W-1:0]   out_id_reg;
    logic              out_line_reg;
    status_t           out_status_reg;
    logic              out_last_reg;
    logic [ID_W-1:0]   sel_id;

    // Memories: one write and one registered read per line.
    always_ff @(posedge aclk) begin
        if (cmd.push_one) begin
            line_one_mem[tail_one_reg] <= id_reg;
        end
        if (cmd.load_item) begin
            rd_one_reg <= line_one_mem[head_one_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push_two) begin
            line_two_mem[tail_two_reg] <= id_reg;
        end
        if (cmd.load_item) begin
            rd_two_reg <= line_two_mem[head_two_reg];
        end
    end

    always_comb begin
        head_one_next = cmd.pop_one  ? ptr_inc(head_one_reg) : head_one_reg;
        tail_one_next = cmd.push_one ? ptr_inc(tail_one_reg) : tail_one_reg;
        head_two_next = cmd.pop_two  ? ptr_inc(head_two_reg) : head_two_reg;
        tail_two_next = cmd.push_two ? ptr_inc(tail_two_reg) : tail_two_reg;
        fill_one_next = fill_one_reg;
        if (cmd.push_one) begin
            fill_one_next = fill_one_reg + FILL_W'(1);
        end else if (cmd.pop_one) begin
            fill_one_next = fill_one_reg - FILL_W'(1);
        end
        fill_two_next = fill_two_reg;
        if (cmd.push_two) begin
            fill_two_next = fill_two_reg + FILL_W'(1);
        end else if (cmd.pop_two) begin
            fill_two_next = fill_two_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_one_reg <= '0;
            tail_one_reg <= '0;
            fill_one_reg <= '0;
            head_two_reg <= '0;
            tail_two_reg <= '0;
            fill_two_reg <= '0;
        end else begin
            head_one_reg <= head_one_next;
            tail_one_reg <= tail_one_next;
            fill_one_reg <= fill_one_next;
            head_two_reg <= head_two_next;
            tail_two_reg <= tail_two_next;
            fill_two_reg <= fill_two_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            action_reg <= in_action;
            id_reg     <= in_id;
        end
    end

    always_comb begin
        case (cmd.id_sel)
            SEL_HEAD_ONE: sel_id = rd_one_reg;
            SEL_HEAD_TWO: sel_id = rd_two_reg;
            default:      sel_id = '0;
        endcase
    end

    // Output register: a new result may replace one taken in the same cycle.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.emit) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_id_reg     <= sel_id;
            out_line_reg   <= cmd.from_line;
            out_status_reg <= cmd.status;
            out_last_reg   <= cmd.last;
        end
    end

    always_comb begin
        stat.action    = action_reg;
        stat.empty_one = (fill_one_reg == '0);
        stat.empty_two = (fill_two_reg == '0);
        stat.full_one  = (fill_one_reg == FILL_W'(QUEUE_DEPTH));
        stat.full_two  = (fill_two_reg == FILL_W'(QUEUE_DEPTH));
        stat.head_lt   = (rd_one_reg < rd_two_reg);
        stat.head_eq   = (rd_one_reg == rd_two_reg);
        stat.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign out_id     = out_id_reg;
    assign out_line   = out_line_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;

endmodule

// ===== rtl/core/tqpm_ctrl.sv =====
// ----------------------------------------------------------------------------
// Two-queue priority merge: controller
// Sequences one item at a time: take the item, evaluate it, and for a round
// with equal heads give the second grant in an extra step.
// ----------------------------------------------------------------------------
module tqpm_ctrl
    import tqpm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t  state_reg, state_next;
    dp_cmd_t plan;
    logic    go_second;
    logic    stall;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // What the current step would do if the output register were free.
    always_comb begin
        plan      = '0;
        plan.id_sel = SEL_ZERO;
        plan.status = ST_GRANT;
        go_second = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                plan.load_item = in_valid;
            end
            S_EVAL: begin
                unique case (stat.action)
                    ACT_PUSH_ONE: begin
                        if (stat.full_one) begin
                            plan.emit   = 1'b1;
                            plan.status = ST_DROP;
                            plan.last   = 1'b1;
                        end else begin
                            plan.push_one = 1'b1;
                        end
                    end
                    ACT_PUSH_TWO: begin
                        if (stat.full_two) begin
                            plan.emit      = 1'b1;
                            plan.from_line = 1'b1;
                            plan.status    = ST_DROP;
                            plan.last      = 1'b1;
                        end else begin
                            plan.push_two = 1'b1;
                        end
                    end
                    ACT_ROUND: begin
                        if (!stat.empty_one &&
                            (stat.empty_two || stat.head_lt || stat.head_eq)) begin
                            go_second    = !stat.empty_two && stat.head_eq;
                            plan.emit    = 1'b1;
                            plan.id_sel  = SEL_HEAD_ONE;
                            plan.last    = !go_second;
                            plan.pop_one = 1'b1;
                        end else if (!stat.empty_two) begin
                            plan.emit      = 1'b1;
                            plan.id_sel    = SEL_HEAD_TWO;
                            plan.from_line = 1'b1;
                            plan.last      = 1'b1;
                            plan.pop_two   = 1'b1;
                        end
                    end
                    ACT_POP_ONE: begin
                        plan.emit = 1'b1;
                        plan.last = 1'b1;
                        if (stat.empty_one) begin
                            plan.status = ST_EMPTY;
                        end else begin
                            plan.status  = ST_DRAIN;
                            plan.id_sel  = SEL_HEAD_ONE;
                            plan.pop_one = 1'b1;
                        end
                    end
                    ACT_POP_TWO: begin
                        plan.emit      = 1'b1;
                        plan.last      = 1'b1;
                        plan.from_line = 1'b1;
                        if (stat.empty_two) begin
                            plan.status = ST_EMPTY;
                        end else begin
                            plan.status  = ST_DRAIN;
                            plan.id_sel  = SEL_HEAD_TWO;
                            plan.pop_two = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_SECOND: begin
                plan.emit      = 1'b1;
                plan.id_sel    = SEL_HEAD_TWO;
                plan.from_line = 1'b1;
                plan.last      = 1'b1;
                plan.pop_two   = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign stall = plan.emit && !stat.out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                if (!stall) begin
                    state_next = go_second ? S_SECOND : S_IDLE;
                end
            end
            S_SECOND: begin
                if (!stall) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd      = stall ? '0 : plan;
        in_ready = (state_reg == S_IDLE);
    end

endmodule

// ===== test/tb_two_queue_priority_merge_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Two-queue priority merge: testbench
// Drives push, round and pop items into the block, predicts every grant,
// drain and error result from a local copy of both lines, and checks each
// result transfer in order under random idling and a long output stall.
// ----------------------------------------------------------------------------
module tb_two_queue_priority_merge_top;
    import tqpm_pkg::*;

    localparam int  CLK_PERIOD   = 10;
    localparam int  RESET_CYCLES = 7;
    localparam int  SETTLE_CYCLES = 8;
    localparam int  TIMEOUT_NS   = 5_000_000;
    localparam int  RANDOM_ITEMS = 150;
    localparam int  MAX_REPORTS  = 10;

    // Action codes that the block must ignore.
    localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
    localparam logic [2:0] ACT_UNUSED_HI = 3'd7;

    // One expected result transfer.
    typedef struct packed {
        logic [15:0] id;
        logic        from_line;
        status_t     status;
        logic        last;
    } grant_rec_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [15:0] person_id
    logic [2:0]  s_tuser;   // [2:0] action
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [15:0] out_id
    logic [2:0]  m_tuser;   // [0] from_line, [2:1] status
    logic        m_tlast;   // last_of_item

    // Local copy of both lines, index 0 is line one.
    logic [15:0] line_mem [2][QUEUE_DEPTH];
    int          line_head [2];
    int          line_tail [2];
    int          line_fill [2];

    grant_rec_t  pending_grants [$];
    int          error_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_left;

    two_queue_priority_merge_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // The run ends here if the block hangs.
    initial begin
        #(TIMEOUT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Line model
    // ------------------------------------------------------------------------

    task automatic expect_result(input logic [15:0] id, input int ln, input status_t st,
                                 input logic last);
        grant_rec_t rec;
        rec.id        = id;
        rec.from_line = ln[0];
        rec.status    = st;
        rec.last      = last;
        pending_grants.push_back(rec);
    endtask

    function automatic logic [15:0] take_head(input int ln);
        logic [15:0] v;
        v             = line_mem[ln][line_head[ln]];
        line_head[ln] = (line_head[ln] + 1) % QUEUE_DEPTH;
        line_fill[ln]--;
        return v;
    endfunction

    // Applies one accepted item to the local lines and queues its results.
    task automatic merge_model_step(input logic [2:0] act, input logic [15:0] id);
        int          ln;
        logic [15:0] h1;
        logic [15:0] h2;
        case (act)
            ACT_PUSH_ONE, ACT_PUSH_TWO: begin
                ln = (act == ACT_PUSH_ONE) ? 0 : 1;
                if (line_fill[ln] >= QUEUE_DEPTH) begin
                    expect_result(16'd0, ln, ST_DROP, 1'b1);
                end else begin
                    line_mem[ln][line_tail[ln]] = id;
                    line_tail[ln] = (line_tail[ln] + 1) % QUEUE_DEPTH;
                    line_fill[ln]++;
                end
            end
            ACT_ROUND: begin
                h1 = line_mem[0][line_head[0]];
                h2 = line_mem[1][line_head[1]];
                if (line_fill[0] != 0 && line_fill[1] != 0 && h1 == h2) begin
                    // Equal heads: line one first, line two closes the item.
                    expect_result(take_head(0), 0, ST_GRANT, 1'b0);
                    expect_result(take_head(1), 1, ST_GRANT, 1'b1);
                end else if (line_fill[0] != 0 && (line_fill[1] == 0 || h1 < h2)) begin
                    expect_result(take_head(0), 0, ST_GRANT, 1'b1);
                end else if (line_fill[1] != 0) begin
                    expect_result(take_head(1), 1, ST_GRANT, 1'b1);
                end
            end
            ACT_POP_ONE, ACT_POP_TWO: begin
                ln = (act == ACT_POP_ONE) ? 0 : 1;
                if (line_fill[ln] == 0) begin
                    expect_result(16'd0, ln, ST_EMPTY, 1'b1);
                end else begin
                    expect_result(take_head(ln), ln, ST_DRAIN, 1'b1);
                end
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // Offers one item after a random gap and returns once it is transferred.
    // tvalid stays high so that the next item can follow without a bubble.
    task automatic send_item(input logic [2:0] act, input logic [15:0] id);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            s_tdata  = $urandom;
            s_tuser  = $urandom;
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = id;
        s_tuser  = act;
        do @(posedge aclk); while (!s_tready);
        merge_model_step(act, id);
    endtask

    // The sender goes quiet until every expected result has come back.
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_grants.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_id();
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: return 16'($urandom_range(15));
            6, 7:             return 16'($urandom);
            8:                return 16'h0000;
            default:          return 16'hFFFF;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Receiver side and result check
    // ------------------------------------------------------------------------

    // A hold-off set by a test is counted down here, one cycle per falling edge.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready = 1'b0;
            end else begin
                m_tready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
    endtask

    always @(posedge aclk) begin : result_check
        grant_rec_t got;
        grant_rec_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.id        = m_tdata;
            got.from_line = m_tuser[0];
            got.status    = status_t'(m_tuser[2:1]);
            got.last      = m_tlast;
            if (pending_grants.size() == 0) begin
                report_error($sformatf("unexpected result id=%h line=%0d status=%0d last=%0d",
                                       got.id, got.from_line, got.status, got.last));
            end else begin
                want = pending_grants.pop_front();
                if (got !== want) begin
                    report_error($sformatf(
                        "mismatch: expected id=%h line=%0d status=%0d last=%0d, got id=%h line=%0d status=%0d last=%0d",
                        want.id, want.from_line, want.status, want.last,
                        got.id, got.from_line, got.status, got.last));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Field extremes, every action and each special case of the merge.
    task automatic test_directed_cases();
        send_item(ACT_POP_ONE, 16'h1234);      // pop on empty line one
        send_item(ACT_POP_TWO, 16'hFFFF);      // pop on empty line two
        send_item(ACT_ROUND, 16'h0000);        // round with both lines empty
        for (int a = ACT_UNUSED_LO; a <= ACT_UNUSED_HI; a++) send_item(a[2:0], 16'hFFFF);
        send_item(ACT_PUSH_ONE, 16'h0000);
        send_item(ACT_PUSH_TWO, 16'h0000);
        send_item(ACT_ROUND, 16'h5555);        // equal heads at zero
        send_item(ACT_PUSH_ONE, 16'hFFFF);
        send_item(ACT_PUSH_TWO, 16'hFFFF);
        send_item(ACT_ROUND, 16'h0000);        // equal heads at the maximum
        send_item(ACT_PUSH_ONE, 16'h8000);
        send_item(ACT_PUSH_TWO, 16'h7FFF);
        send_item(ACT_ROUND, 16'h0000);        // smaller head on line two
        send_item(ACT_ROUND, 16'h0000);        // only line one holds an id
        send_item(ACT_PUSH_TWO, 16'h0001);
        send_item(ACT_ROUND, 16'h0000);        // only line two holds an id
        send_item(ACT_PUSH_ONE, 16'h0002);
        send_item(ACT_PUSH_TWO, 16'h0003);
        send_item(ACT_ROUND, 16'h0000);        // smaller head on line one
        send_item(ACT_POP_TWO, 16'h0000);      // leftover drained from line two
        send_item(ACT_PUSH_ONE, 16'hAAAA);
        send_item(ACT_POP_ONE, 16'h0000);      // leftover drained from line one
        send_item(ACT_POP_ONE, 16'h0000);
        wait_drained();
    endtask

    // Both lines are topped up to the brim and then overfilled, which also
    // walks each tail pointer around its wrap. The lines are left full.
    task automatic test_full_lines();
        while (line_fill[0] < QUEUE_DEPTH || line_fill[1] < QUEUE_DEPTH) begin
            if (line_fill[0] < QUEUE_DEPTH) send_item(ACT_PUSH_ONE, 16'($urandom_range(31)));
            if (line_fill[1] < QUEUE_DEPTH) send_item(ACT_PUSH_TWO, 16'($urandom_range(31)));
        end
        send_item(ACT_PUSH_ONE, 16'hFFFF);
        send_item(ACT_PUSH_TWO, 16'h0000);
        send_item(ACT_PUSH_TWO, 16'h1357);
        send_item(ACT_PUSH_ONE, 16'h2468);
        wait_drained();
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering result-producing items, so the block must stall its input.
    task automatic test_output_backpressure();
        int saved;
        saved         = send_idle_pct;
        send_idle_pct = 0;
        hold_left     = 250;
        for (int i = 0; i < 10; i++) begin
            send_item(ACT_PUSH_ONE, 16'($urandom_range(7)));
            send_item(ACT_PUSH_TWO, 16'($urandom_range(7)));
        end
        for (int i = 0; i < 30; i++) begin
            if (i % 3 == 2) send_item(ACT_POP_ONE, 16'h0000);
            else            send_item(ACT_ROUND, 16'h0000);
        end
        send_idle_pct = saved;
        wait_drained();
    endtask

    // Mostly pushes and rounds with random content, some pops and a few
    // ignored codes, in three idling phases.
    task automatic test_random_mix();
        int sent;
        int r;
        int phase_len;
        phase_len = RANDOM_ITEMS / 3;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 36; recv_idle_pct = 65; end
                1:       begin send_idle_pct = 65; recv_idle_pct = 36; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            sent = 0;
            while (sent < phase_len) begin
                r = $urandom_range(99);
                if (r < 28)      send_item(ACT_PUSH_ONE, pick_id());
                else if (r < 56) send_item(ACT_PUSH_TWO, pick_id());
                else if (r < 82) send_item(ACT_ROUND, pick_id());
                else if (r < 89) send_item(ACT_POP_ONE, pick_id());
                else if (r < 96) send_item(ACT_POP_TWO, pick_id());
                else             send_item(3'($urandom_range(ACT_UNUSED_HI, ACT_UNUSED_LO)),
                                           16'($urandom));
                // Ignored codes do not count toward the item total.
                if (r < 96) sent++;
                if (sent == phase_len / 2 && r < 96) wait_drained();
            end
            wait_drained();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        error_count   = 0;
        hold_left     = 0;
        send_idle_pct = 36;
        recv_idle_pct = 65;
        for (int ln = 0; ln < 2; ln++) begin
            line_head[ln] = 0;
            line_tail[ln] = 0;
            line_fill[ln] = 0;
        end
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed_cases();
        test_random_mix();
        test_full_lines();
        test_output_backpressure();

        if (error_count == 0 && pending_grants.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
